/* rtl/mcbp_pkg.sv */
// shared constants, types and helpers of the byte pipe fifo
package mcbp_pkg;

   localparam int NUM_PIPES   = 8;
   localparam int PIPE_DEPTH  = 512;
   localparam int SLOT_W      = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
   localparam int PTR_W       = $clog2(PIPE_DEPTH);
   localparam int LVL_W       = $clog2(PIPE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(NUM_PIPES * PIPE_DEPTH);

   localparam int CMD_W       = 2;
   localparam int DESC_W      = 10;
   localparam int DATA_W      = 8;
   localparam int LEN_W       = 7;
   localparam int STAT_W      = 3;
   localparam int CMP_W       = (LVL_W > LEN_W) ? LVL_W : LEN_W;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;

   localparam int DESC_BASE   = 100;
   localparam int MAX_READ    = 64;

   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOSLOT = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

   typedef struct packed {
      logic [LVL_W-1:0] fill;
      logic [PTR_W-1:0] tail;
      logic [PTR_W-1:0] head;
   } ptr_entry_type;

   localparam int PTR_ENTRY_W = $bits(ptr_entry_type);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_data;
      logic              last;
      logic [DESC_W-1:0] read_end;
      logic [DESC_W-1:0] write_end;
   } rsp_beat_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } rsp_push_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } obuf_status_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(PIPE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [PTR_W-1:0] ptr);
      logic [ADDR_W-1:0] res;
      res = ADDR_W'(slot) * ADDR_W'(PIPE_DEPTH) + ADDR_W'(ptr);
      return res;
   endfunction

endpackage

/* rtl/mcbp_ram.sv */
// generic simple dual port ram with registered read
module mcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/mcbp_obuf.sv */
// two-entry result buffer driving the rsp stream
module mcbp_obuf (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mcbp_pkg::rsp_push_type                push,
   output mcbp_pkg::obuf_status_type             obuf_status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mcbp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // status, read_data, read_end, write_end
   output logic                                  rsp_tlast
);
   import mcbp_pkg::*;

   rsp_beat_type ent_ff [2];
   logic         wr_ff;
   logic         wr_in;
   logic         rd_ff;
   logic         rd_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         pop;
   rsp_beat_type head_beat;

   assign head_beat  = ent_ff[rd_ff];
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = RSP_TDATA_W'({head_beat.write_end, head_beat.read_end,
                                     head_beat.read_data, head_beat.status});
   assign rsp_tlast  = head_beat.last;

   assign obuf_status.count = count_ff;
   assign obuf_status.pop   = pop;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push.valid) begin
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         ent_ff[wr_ff] <= push.beat;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |-> (count_ff != 2'd2))
      else $error("result beat pushed into a full buffer");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("buffer count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd1) |-> (wr_ff == rd_ff))
      else $error("buffer pointers disagree with count");

endmodule

/* rtl/mcbp_ctrl.sv */
// command sequencer: pointer table read-modify-write and byte store access
module mcbp_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mcbp_pkg::REQ_TDATA_W-1:0]      req_tdata,  // descriptor, write_data, read_length
   input  logic [mcbp_pkg::CMD_W-1:0]            req_tuser,  // command
   output logic                                  ptr_we,
   output logic [mcbp_pkg::SLOT_W-1:0]           ptr_waddr,
   output logic [mcbp_pkg::PTR_ENTRY_W-1:0]      ptr_wdata,
   output logic                                  ptr_re,
   output logic [mcbp_pkg::SLOT_W-1:0]           ptr_raddr,
   input  logic [mcbp_pkg::PTR_ENTRY_W-1:0]      ptr_rdata,
   output logic                                  byte_we,
   output logic [mcbp_pkg::ADDR_W-1:0]           byte_waddr,
   output logic [mcbp_pkg::DATA_W-1:0]           byte_wdata,
   output logic                                  byte_re,
   output logic [mcbp_pkg::ADDR_W-1:0]           byte_raddr,
   input  logic [mcbp_pkg::DATA_W-1:0]           byte_rdata,
   output mcbp_pkg::rsp_push_type                push,
   input  mcbp_pkg::obuf_status_type             obuf_status
);
   import mcbp_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [NUM_PIPES-1:0] active_ff, active_in;
   logic                 inflight_ff, inflight_in;
   logic                 last_ff, last_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;

   logic [CMD_W-1:0]     cmd_ff;
   logic                 bad_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [DATA_W-1:0]    wdata_ff;
   logic [LEN_W-1:0]     len_ff;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [LVL_W-1:0]     fill_ff, fill_in;

   logic [DESC_W-1:0]    req_desc;
   logic [DATA_W-1:0]    req_wdata;
   logic [LEN_W-1:0]     req_len;
   logic [DESC_W-1:0]    desc_off;
   logic [DESC_W-2:0]    slot_wide;
   logic                 req_bad;
   logic                 accept;

   logic [2:0]           occ;
   logic                 room;
   logic                 free_found;
   logic [SLOT_W-1:0]    free_slot;
   logic                 slot_ok;
   ptr_entry_type        look_ptr;
   ptr_entry_type        wr_entry;
   logic [LEN_W-1:0]     len_clip;
   logic [LEN_W-1:0]     run_len;
   logic [DESC_W-1:0]    rend;

   assign req_desc  = req_tdata[DESC_W-1:0];
   assign req_wdata = req_tdata[DESC_W +: DATA_W];
   assign req_len   = req_tdata[DESC_W+DATA_W +: LEN_W];
   assign desc_off  = req_desc - DESC_W'(DESC_BASE);
   assign slot_wide = desc_off[DESC_W-1:1];
   assign req_bad   = (req_desc < DESC_W'(DESC_BASE)) ||
                      (slot_wide >= (DESC_W-1)'(NUM_PIPES));

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ptr_re     = accept;
   assign ptr_raddr  = slot_wide[SLOT_W-1:0];

   // buffer slots taken once in-flight byte lands, less the beat leaving now
   assign occ  = {1'b0, obuf_status.count} + {2'b0, inflight_ff} - {2'b0, obuf_status.pop};
   assign room = (occ <= 3'd1);

   assign look_ptr = ptr_entry_type'(ptr_rdata);
   assign slot_ok  = !bad_ff && active_ff[slot_ff];
   assign len_clip = (len_ff > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : len_ff;
   assign run_len  = (CMP_W'(len_clip) < CMP_W'(look_ptr.fill)) ? len_clip
                                                                : LEN_W'(look_ptr.fill);
   assign rend     = DESC_W'(DESC_BASE) + DESC_W'({free_slot, 1'b0});

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_PIPES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      inflight_in = 1'b0;
      last_in     = last_ff;
      cnt_in      = cnt_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      ptr_we      = 1'b0;
      ptr_waddr   = slot_ff;
      wr_entry    = '0;
      byte_we     = 1'b0;
      byte_waddr  = byte_addr(slot_ff, look_ptr.tail);
      byte_wdata  = wdata_ff;
      byte_re     = 1'b0;
      byte_raddr  = byte_addr(slot_ff, head_ff);
      push        = '0;

      if (inflight_ff) begin
         push.valid          = 1'b1;
         push.beat.status    = ST_OK;
         push.beat.read_data = byte_rdata;
         push.beat.last      = last_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (room) begin
               state_in       = S_IDLE;
               push.valid     = 1'b1;
               push.beat.last = 1'b1;
               case (cmd_ff)
                  CMD_CREATE: begin
                     if (free_found) begin
                        active_in[free_slot] = 1'b1;
                        ptr_we               = 1'b1;
                        ptr_waddr            = free_slot;
                        push.beat.status     = ST_OK;
                        push.beat.read_end   = rend;
                        push.beat.write_end  = rend + DESC_W'(1);
                     end else begin
                        push.beat.status = ST_NOSLOT;
                     end
                  end
                  CMD_WRITE: begin
                     if (!slot_ok) begin
                        push.beat.status = ST_BAD;
                     end else if (look_ptr.fill >= LVL_W'(PIPE_DEPTH)) begin
                        push.beat.status = ST_FULL;
                     end else begin
                        byte_we          = 1'b1;
                        ptr_we           = 1'b1;
                        wr_entry.head    = look_ptr.head;
                        wr_entry.tail    = next_ptr(look_ptr.tail);
                        wr_entry.fill    = look_ptr.fill + 1'b1;
                        push.beat.status = ST_OK;
                     end
                  end
                  CMD_READ: begin
                     if (!slot_ok) begin
                        push.beat.status = ST_BAD;
                     end else if (look_ptr.fill == '0) begin
                        push.beat.status = ST_EMPTY;
                     end else if (len_ff == '0) begin
                        push.valid = 1'b0;
                     end else begin
                        push.valid = 1'b0;
                        state_in   = S_READ;
                        head_in    = look_ptr.head;
                        tail_in    = look_ptr.tail;
                        fill_in    = look_ptr.fill;
                        cnt_in     = run_len;
                     end
                  end
                  default: begin
                     push.beat.status = ST_BAD;
                  end
               endcase
            end
         end
         S_READ: begin
            if (room) begin
               byte_re     = 1'b1;
               inflight_in = 1'b1;
               last_in     = (cnt_ff == LEN_W'(1));
               head_in     = next_ptr(head_ff);
               fill_in     = fill_ff - 1'b1;
               cnt_in      = cnt_ff - 1'b1;
               if (cnt_ff == LEN_W'(1)) begin
                  state_in      = S_IDLE;
                  ptr_we        = 1'b1;
                  wr_entry.head = next_ptr(head_ff);
                  wr_entry.tail = tail_ff;
                  wr_entry.fill = fill_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ptr_wdata = PTR_ENTRY_W'(wr_entry);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         active_ff   <= '0;
         inflight_ff <= 1'b0;
         last_ff     <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         inflight_ff <= inflight_in;
         last_ff     <= last_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser;
         bad_ff   <= req_bad;
         slot_ff  <= slot_wide[SLOT_W-1:0];
         wdata_ff <= req_wdata;
         len_ff   <= req_len;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
      fill_ff <= fill_in;
   end

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (cnt_ff != '0))
      else $error("read run active with no bytes left");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK && slot_ok) |-> (look_ptr.fill <= LVL_W'(PIPE_DEPTH)))
      else $error("pipe fill level above depth");

   a_push_source: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !inflight_ff) |-> (state_ff == S_LOOK))
      else $error("status beat pushed outside lookup");

   a_run_room: assert property (@(posedge clock) disable iff (reset)
      byte_re |-> (state_ff == S_READ) && (cnt_ff != '0) && slot_ok)
      else $error("byte read issued outside a valid read run");

endmodule

/* rtl/multi_channel_byte_pipe_fifo_core.sv */
// top level of the multi-channel byte pipe fifo
//
// keeps NUM_PIPES circular byte fifos of PIPE_DEPTH bytes in one shared byte ram,
// with the head, tail and fill of each pipe in a small pointer ram.
// req channel: one command beat (tuser = command: create, write, read);
// tdata carries descriptor, write byte and read length.
// rsp channel: one beat per result; tlast marks the final beat of a command.
// create returns read and write descriptors 100+2i and 101+2i of the lowest free slot.
// a command is taken in idle and its pointer entry is looked up the next cycle;
// create and write finish there once the buffer has room, and their beat goes
// to rsp through the result buffer.
// a read of n bytes returns at most min(n, 64, fill) bytes, one byte ram read per cycle
// while the buffer has room; the byte ram read port sets that rate.
// results go through a two-entry buffer; while rsp stalls, the byte reads
// pause as soon as the buffer and the read in flight would fill it.
// reset clears the active flags of all slots and empties the buffer; pointer
// and byte rams need no clearing since a slot is reinitialized on create.
module multi_channel_byte_pipe_fifo_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mcbp_pkg::REQ_TDATA_W-1:0]      req_tdata,  // descriptor, write_data, read_length
   input  logic [mcbp_pkg::CMD_W-1:0]            req_tuser,  // command
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mcbp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // status, read_data, read_end, write_end
   output logic                                  rsp_tlast   // last
);
   import mcbp_pkg::*;

   logic                   ptr_we;
   logic [SLOT_W-1:0]      ptr_waddr;
   logic [PTR_ENTRY_W-1:0] ptr_wdata;
   logic                   ptr_re;
   logic [SLOT_W-1:0]      ptr_raddr;
   logic [PTR_ENTRY_W-1:0] ptr_rdata;
   logic                   byte_we;
   logic [ADDR_W-1:0]      byte_waddr;
   logic [DATA_W-1:0]      byte_wdata;
   logic                   byte_re;
   logic [ADDR_W-1:0]      byte_raddr;
   logic [DATA_W-1:0]      byte_rdata;
   rsp_push_type           push;
   obuf_status_type        obuf_status;

   mcbp_ram #(
      .WIDTH (PTR_ENTRY_W),
      .DEPTH (NUM_PIPES)
   ) u_ptr_ram (
      .clock (clock),
      .we    (ptr_we),
      .waddr (ptr_waddr),
      .wdata (ptr_wdata),
      .re    (ptr_re),
      .raddr (ptr_raddr),
      .rdata (ptr_rdata)
   );

   mcbp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_PIPES * PIPE_DEPTH)
   ) u_byte_ram (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (byte_wdata),
      .re    (byte_re),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

   mcbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .ptr_we      (ptr_we),
      .ptr_waddr   (ptr_waddr),
      .ptr_wdata   (ptr_wdata),
      .ptr_re      (ptr_re),
      .ptr_raddr   (ptr_raddr),
      .ptr_rdata   (ptr_rdata),
      .byte_we     (byte_we),
      .byte_waddr  (byte_waddr),
      .byte_wdata  (byte_wdata),
      .byte_re     (byte_re),
      .byte_raddr  (byte_raddr),
      .byte_rdata  (byte_rdata),
      .push        (push),
      .obuf_status (obuf_status)
   );

   mcbp_obuf u_obuf (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .obuf_status (obuf_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* tb/testbench.sv */
// self-checking testbench for the multi-channel byte pipe fifo core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mcbp_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int RANDOM_ITEMS  = 144;
   localparam int QUIET_ITEMS   = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 16;
   localparam int FILL_SLOT     = 3;
   localparam int FILL_WRITES   = 40;
   localparam int FILL_READS    = 2;

   class pipe_scoreboard;
      bit               slot_active [NUM_PIPES];
      int unsigned      head_ptr [NUM_PIPES];
      int unsigned      tail_ptr [NUM_PIPES];
      int unsigned      fill_count [NUM_PIPES];
      logic [7:0]       pipe_bytes [NUM_PIPES][PIPE_DEPTH];
      rsp_beat_type     expected_beats [$];
      int               fail_count;

      function new();
         fail_count = 0;
         for (int i = 0; i < NUM_PIPES; i++) begin
            slot_active[i] = 1'b0;
            head_ptr[i]    = 0;
            tail_ptr[i]    = 0;
            fill_count[i]  = 0;
         end
      endfunction

      function void push_beat(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data,
                              logic last, logic [DESC_W-1:0] rend,
                              logic [DESC_W-1:0] wend);
         rsp_beat_type beat;
         beat.status    = status;
         beat.read_data = data;
         beat.last      = last;
         beat.read_end  = rend;
         beat.write_end = wend;
         expected_beats.push_back(beat);
      endfunction

      function int find_slot(logic [DESC_W-1:0] desc);
         int unsigned s;
         if (desc < DESC_BASE) return -1;
         s = (desc - DESC_BASE) / 2;
         if (s >= NUM_PIPES || !slot_active[s]) return -1;
         return s;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [DESC_W-1:0] desc,
                                 logic [DATA_W-1:0] wdata, logic [LEN_W-1:0] len);
         int          slot;
         int unsigned count;
         if (cmd == CMD_CREATE) begin
            for (int i = 0; i < NUM_PIPES; i++) begin
               if (!slot_active[i]) begin
                  slot_active[i] = 1'b1;
                  head_ptr[i]    = 0;
                  tail_ptr[i]    = 0;
                  fill_count[i]  = 0;
                  push_beat(ST_OK, '0, 1'b1, DESC_W'(DESC_BASE + 2 * i),
                            DESC_W'(DESC_BASE + 2 * i + 1));
                  return;
               end
            end
            push_beat(ST_NOSLOT, '0, 1'b1, '0, '0);
            return;
         end
         if (cmd == CMD_UNUSED) begin
            push_beat(ST_BAD, '0, 1'b1, '0, '0);
            return;
         end
         slot = find_slot(desc);
         if (slot < 0) begin
            push_beat(ST_BAD, '0, 1'b1, '0, '0);
            return;
         end
         if (cmd == CMD_WRITE) begin
            if (fill_count[slot] >= PIPE_DEPTH) begin
               push_beat(ST_FULL, '0, 1'b1, '0, '0);
               return;
            end
            pipe_bytes[slot][tail_ptr[slot]] = wdata;
            tail_ptr[slot] = (tail_ptr[slot] + 1) % PIPE_DEPTH;
            fill_count[slot]++;
            push_beat(ST_OK, '0, 1'b1, '0, '0);
            return;
         end
         if (fill_count[slot] == 0) begin
            push_beat(ST_EMPTY, '0, 1'b1, '0, '0);
            return;
         end
         count = (len > MAX_READ) ? MAX_READ : len;
         if (count > fill_count[slot]) count = fill_count[slot];
         for (int unsigned i = 0; i < count; i++) begin
            push_beat(ST_OK, pipe_bytes[slot][head_ptr[slot]], i + 1 == count, '0, '0);
            head_ptr[slot] = (head_ptr[slot] + 1) % PIPE_DEPTH;
            fill_count[slot]--;
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
         end
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata, logic tlast);
         rsp_beat_type exp_beat;
         if (expected_beats.size() == 0) begin
            $error("response beat with nothing expected: tdata %h, tlast %b", tdata, tlast);
            fail_count++;
            return;
         end
         exp_beat = expected_beats.pop_front();
         compare_field("status", 32'(exp_beat.status), 32'(tdata[2:0]));
         compare_field("read_data", 32'(exp_beat.read_data), 32'(tdata[10:3]));
         compare_field("last", 32'(exp_beat.last), 32'(tlast));
         compare_field("read_end", 32'(exp_beat.read_end), 32'(tdata[20:11]));
         compare_field("write_end", 32'(exp_beat.write_end), 32'(tdata[30:21]));
      endfunction

      function int pending_count();
         return expected_beats.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // descriptor, write_data, read_length
   logic [CMD_W-1:0]       req_tuser;   // command
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // status, read_data, read_end, write_end
   logic                   rsp_tlast;   // last

   bit          idle_enabled  = 1'b1;
   bit          hold_request  = 1'b0;
   int unsigned cycle_count   = 0;
   pipe_scoreboard board = new();

   multi_channel_byte_pipe_fifo_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata, rsp_tlast);
      end
   end

   // receiver side: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_request(input logic [CMD_W-1:0] cmd, input int unsigned desc,
                               input int unsigned wdata, input int unsigned len);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, LEN_W'(len), DATA_W'(wdata), DESC_W'(desc)};
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(cmd, DESC_W'(desc), DATA_W'(wdata), LEN_W'(len));
   endtask

   task automatic send_random_item();
      int unsigned pick;
      int unsigned slot;
      int unsigned desc;
      int unsigned len_pick;
      int unsigned len;
      pick     = $urandom_range(0, 99);
      slot     = $urandom_range(0, NUM_PIPES - 1);
      desc     = DESC_BASE + 2 * slot + $urandom_range(0, 1);
      len_pick = $urandom_range(0, 19);
      if (len_pick == 0) len = 0;
      else if (len_pick <= 2) len = $urandom_range(65, 127);
      else if (len_pick <= 5) len = $urandom_range(17, 64);
      else len = $urandom_range(1, 16);
      if (pick < 55) begin
         send_request(CMD_WRITE, desc, $urandom_range(0, 255), $urandom_range(0, 127));
      end else if (pick < 85) begin
         send_request(CMD_READ, desc, $urandom_range(0, 255), len);
      end else if (pick < 90) begin
         send_request($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, $urandom_range(0, 1023),
                      $urandom_range(0, 255), $urandom_range(0, 127));
      end else if (pick < 95) begin
         send_request(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 255),
                      $urandom_range(0, 127));
      end else begin
         send_request(CMD_CREATE, $urandom_range(0, 1023), $urandom_range(0, 255),
                      $urandom_range(0, 127));
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_CREATE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no pipe yet: bad descriptors and the unused command
      send_request(CMD_READ, 100, 8'h00, 1);
      send_request(CMD_WRITE, 0, 8'hFF, 0);
      send_request(CMD_READ, 99, 8'h00, 127);
      send_request(CMD_UNUSED, 100, 8'h00, 0);
      for (int i = 0; i < NUM_PIPES; i++) begin
         send_request(CMD_CREATE, $urandom_range(0, 1023), $urandom_range(0, 255),
                      $urandom_range(0, 127));
      end
      send_request(CMD_CREATE, 1023, 8'hFF, 127);
      send_request(CMD_WRITE, 100, 8'h00, 0);
      send_request(CMD_WRITE, 101, 8'hFF, 127);
      send_request(CMD_WRITE, 115, 8'hA5, 64);
      send_request(CMD_READ, 100, 8'h00, 0);
      send_request(CMD_READ, 101, 8'hFF, 127);
      send_request(CMD_READ, 100, 8'h00, 1);
      send_request(CMD_WRITE, 116, 8'h5A, 1);
      send_request(CMD_READ, 1023, 8'h00, 64);
      send_request(CMD_WRITE, 114, 8'h5A, 0);
      send_request(CMD_READ, 115, 8'h00, 64);
      send_request(CMD_UNUSED, 1023, 8'hFF, 127);

      // stall the block under a long receiver hold-off, then drain the pipe
      hold_request = 1'b1;
      repeat (FILL_WRITES) begin
         send_request(CMD_WRITE, DESC_BASE + 2 * FILL_SLOT + $urandom_range(0, 1),
                      $urandom_range(0, 255), $urandom_range(0, 127));
      end
      repeat (FILL_READS) begin
         send_request(CMD_READ, DESC_BASE + 2 * FILL_SLOT + $urandom_range(0, 1),
                      $urandom_range(0, 255), $urandom_range(MAX_READ, 127));
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_enabled = 1'b0;
         send_random_item();
      end
      req_tvalid <= 1'b0;

      while (board.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
